@@ src/mdiv_pkg.sv @@
// shared constants for the multiply-divide core
package mdiv_pkg;

  // width of each operand and result port
  localparam int unsigned DataWidth = 64;

  // default width of the arithmetic inside the core
  localparam int unsigned OperandWidthDefault = 64;

endpackage

@@ src/mul_div_64_core.sv @@
// pipelined floor(multiplicand * multiplier / divisor) with a double-width product
// stages in order: operand capture, half-width products, product sum, then the divider steps
// throughput: one item per cycle while the output is not stalled; the divider is one restoring stage per product bit
// the multiplier is split into four half-width products, registered, then summed
// the whole pipe advances together when the output register is empty or being taken
// reset clears all valid bits; payload registers are not reset
module mul_div_64_core #(
  parameter int unsigned OPERAND_WIDTH = mdiv_pkg::OperandWidthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [mdiv_pkg::DataWidth-1:0] multiplicand_i,
  input  logic [mdiv_pkg::DataWidth-1:0] multiplier_i,
  input  logic [mdiv_pkg::DataWidth-1:0] divisor_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mdiv_pkg::DataWidth-1:0] quotient_o,
  output logic                           divide_by_zero_o
);
  import mdiv_pkg::*;

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned H  = W / 2;
  localparam int unsigned HH = W - H;
  localparam int unsigned NS = 2 * W;

  logic adv;

  // input operand stage
  logic         va_q;
  logic [W-1:0] a_q, b_q, c_q;

  // partial product stage
  logic            vb_q;
  logic [2*H-1:0]  ll_q;
  logic [H+HH-1:0] lh_q, hl_q;
  logic [2*HH-1:0] hh_q;
  logic [W-1:0]    cb_q;

  // divider stages, index 0 holds the finished product
  logic          v_q   [0:NS];
  logic [W-1:0]  rem_q [0:NS];
  logic [NS-1:0] prod_q[0:NS];
  logic [W-1:0]  quo_q [0:NS];
  logic [W-1:0]  d_q   [0:NS];

  // whole pipe moves when the output slot frees up
  assign adv        = !v_q[NS] || out_ready_i;
  assign in_ready_o = adv;

  // valid bits of the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (adv) begin
      va_q <= in_valid_i;
      vb_q <= va_q;
    end
  end

  // operand capture and half-width products
  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q  <= multiplicand_i[W-1:0];
      b_q  <= multiplier_i[W-1:0];
      c_q  <= divisor_i[W-1:0];
      ll_q <= a_q[H-1:0] * b_q[H-1:0];
      lh_q <= a_q[H-1:0] * b_q[W-1:H];
      hl_q <= a_q[W-1:H] * b_q[H-1:0];
      hh_q <= a_q[W-1:H] * b_q[W-1:H];
      cb_q <= c_q;
    end
  end

  // sum of partial products into the full product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (adv) begin
      v_q[0] <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q[0] <= NS'(ll_q) + (NS'(lh_q) << H) + (NS'(hl_q) << H) + (NS'(hh_q) << (2 * H));
      rem_q[0]  <= '0;
      quo_q[0]  <= '0;
      d_q[0]    <= cb_q;
    end
  end

  // one restoring division step per stage, msb of the product first
  for (genvar k = 0; k < NS; k++) begin : g_div
    logic [W:0] trial;
    logic       ge;

    assign trial = {rem_q[k], prod_q[k][NS-1]};
    assign ge    = trial >= {1'b0, d_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (adv) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rem_q[k+1]  <= ge ? W'(trial - {1'b0, d_q[k]}) : W'(trial);
        prod_q[k+1] <= {prod_q[k][NS-2:0], 1'b0};
        quo_q[k+1]  <= {quo_q[k][W-2:0], ge};
        d_q[k+1]    <= d_q[k];
      end
    end
  end

  // last stage is the output register; zero divisor forces all ones
  assign out_valid_o      = v_q[NS];
  assign divide_by_zero_o = (d_q[NS] == '0);
  assign quotient_o       = DataWidth'(divide_by_zero_o ? {W{1'b1}} : quo_q[NS]);

endmodule

@@ sim/testbench.sv @@
// self-checking testbench for the pipelined multiply-divide core
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned W = mdiv_pkg::DataWidth;
  localparam int unsigned OpWidth = mdiv_pkg::OperandWidthDefault;
  localparam int unsigned Latency = 2 * OpWidth + 2;

  typedef struct packed {
    logic [W-1:0] quotient;
    logic         div_zero;
  } quot_t;

  // expected quotients in order of acceptance
  class quot_board;
    quot_t pending[$];
    int    errors;

    function automatic logic [W-1:0] op_mask();
      return (OpWidth >= W) ? '1 : (({{W{1'b0}}, 1'b1} << OpWidth) - 1);
    endfunction

    // scaled quotient of one operand set
    function automatic quot_t scale_quotient(logic [W-1:0] a, logic [W-1:0] b,
                                             logic [W-1:0] c);
      logic [2*W-1:0] prod;
      logic [2*W-1:0] quo;
      quot_t r;
      a = a & op_mask();
      b = b & op_mask();
      c = c & op_mask();
      if (c == '0) begin
        r.quotient = op_mask();
        r.div_zero = 1'b1;
      end else begin
        prod = {{W{1'b0}}, a} * {{W{1'b0}}, b};
        quo = prod / {{W{1'b0}}, c};
        r.quotient = quo[W-1:0] & op_mask();
        r.div_zero = 1'b0;
      end
      return r;
    endfunction

    function void note_operands(logic [W-1:0] a, logic [W-1:0] b, logic [W-1:0] c);
      pending.push_back(scale_quotient(a, b, c));
    endfunction

    function void check_quotient(logic [W-1:0] q, logic dz);
      quot_t e;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected item q=%h dz=%b", q, dz));
        return;
      end
      e = pending.pop_front();
      if (q !== e.quotient)
        report_mismatch($sformatf("quotient %h, want %h", q, e.quotient));
      if (dz !== e.div_zero)
        report_mismatch($sformatf("divide_by_zero %b, want %b", dz, e.div_zero));
    endfunction

    function void report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         in_valid_i = 1'b0;
  logic         in_ready_o;
  logic [W-1:0] multiplicand_i = '0;
  logic [W-1:0] multiplier_i = '0;
  logic [W-1:0] divisor_i = '0;
  logic         out_valid_o;
  logic         out_ready_i = 1'b0;
  logic [W-1:0] quotient_o;
  logic         divide_by_zero_o;

  quot_board board = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;

  mul_div_64_core dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .multiplicand_i,
    .multiplier_i,
    .divisor_i,
    .out_valid_o,
    .out_ready_i,
    .quotient_o,
    .divide_by_zero_o
  );

  always #5 clk_i = ~clk_i;

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_quotient(quotient_o, divide_by_zero_o);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // operand with a random bit span, to hit small and large values
  function automatic logic [W-1:0] rand_span();
    int s;
    s = $urandom_range(W);
    return (s == 0) ? '0 : rand_word() >> (W - s);
  endfunction

  // offer one item and wait for acceptance
  task automatic send_item(logic [W-1:0] a, logic [W-1:0] b, logic [W-1:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    multiplicand_i <= a;
    multiplier_i <= b;
    divisor_i <= c;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_operands(a, b, c);
  endtask

  task automatic send_random(int n);
    logic [W-1:0] a, b, c;
    for (int i = 0; i < n; i++) begin
      a = ($urandom_range(3) == 0) ? rand_word() : rand_span();
      b = ($urandom_range(3) == 0) ? rand_word() : rand_span();
      c = ($urandom_range(15) == 0) ? '0 : rand_span();
      if ($urandom_range(7) == 0) c = rand_word();
      send_item(a, b, c);
    end
  endtask

  initial begin
    #2ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [W-1:0] ones;
    int waited;
    ones = '1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, zero divisor, overflow, exact
    send_item('0, '0, '0);
    send_item(ones, ones, '0);
    send_item(ones, ones, ones);
    send_item(ones, ones, 1);
    send_item(ones, 2, 1);
    send_item('0, ones, 1);
    send_item(ones, ones, 2);
    send_item(1, 1, ones);
    send_item(ones, 1, ones);
    send_item(64'h8000_0000_0000_0000, 2, 3);
    send_item(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    send_item(12345, 67890, 7);
    send_item(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'hFFFF_FFFF);
    send_item(ones, ones, 64'h1_0000_0000);
    send_item(7, 3, 22);

    // random phases with different idling mixes
    send_random(75);
    send_idle_pct = 69;
    send_random(65);
    send_idle_pct = 0;
    recv_stall_pct = 69;
    send_random(65);
    send_idle_pct = 6;
    recv_stall_pct = 6;
    send_random(65);

    // long receiver hold-off while items keep coming
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 400;
    send_random(200);
    send_random(30);

    in_valid_i <= 1'b0;
    waited = 0;
    while (board.pending.size() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (Latency + 10) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
